// ===== rtl/core/cale_pkg.sv =====
package cale_pkg;

  // default build-time sizes
  localparam int unsigned CAPACITY_DEF   = 8;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // fixed field widths of the command and response channels
  localparam int unsigned OP_W      = 4;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned CNT_OUT_W = 4;

  typedef enum logic [OP_W-1:0] {
    OP_START  = 4'd0,
    OP_END    = 4'd1,
    OP_NEXT   = 4'd2,
    OP_BACK   = 4'd3,
    OP_GET    = 4'd4,
    OP_UPDATE = 4'd5,
    OP_APPEND = 4'd6,
    OP_REMOVE = 4'd7,
    OP_CLEAR  = 4'd8
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD_WAIT,
    S_SHIFT,
    S_DONE
  } state_e;

  // finished command handed from the sequencer to the output stage
  typedef struct packed {
    logic    valid;
    status_e status;
  } res_t;

endpackage

// ===== rtl/core/cale_if.sv =====
interface cale_cmd_if
  import cale_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic signed [VAL_W-1:0] data_value;

  modport source (output valid, output operation, output data_value, input ready);
  modport sink   (input valid, input operation, input data_value, output ready);
endinterface

interface cale_rsp_if
  import cale_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] read_value;
  logic [STAT_W-1:0]       status;
  logic [CNT_OUT_W-1:0]    element_count;
  logic [CNT_OUT_W-1:0]    cursor_index;

  modport source (output valid, output read_value, output status, output element_count,
                  output cursor_index, input ready);
  modport sink   (input valid, input read_value, input status, input element_count,
                  input cursor_index, output ready);
endinterface

// ===== rtl/core/cale_mem.sv =====
module cale_mem
  import cale_pkg::*;
#(
  parameter int unsigned DEPTH = CAPACITY_DEF,
  parameter int unsigned WIDTH = DATA_WIDTH_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/cale_ctrl.sv =====
module cale_ctrl
  import cale_pkg::*;
#(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int unsigned AW        = $clog2(CAPACITY),
  localparam int unsigned CW        = $clog2(CAPACITY + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  output logic                  cmd_ready_o,
  input  op_e                   op_i,
  input  logic [DATA_WIDTH-1:0] data_i,
  input  logic                  res_take_i,
  output res_t                  res_o,
  output logic [DATA_WIDTH-1:0] rd_val_o,
  output logic [CW-1:0]         count_o,
  output logic [CW-1:0]         cursor_o,
  output logic                  we_o,
  output logic [AW-1:0]         waddr_o,
  output logic [DATA_WIDTH-1:0] wdata_o,
  output logic                  re_o,
  output logic [AW-1:0]         raddr_o,
  input  logic [DATA_WIDTH-1:0] rdata_i
);

  state_e                state_q, state_d;
  logic [CW-1:0]         count_q, count_d;
  logic [CW-1:0]         cursor_q, cursor_d;
  logic [AW-1:0]         idx_q, idx_d;
  status_e               status_q, status_d;
  logic [DATA_WIDTH-1:0] rdval_q, rdval_d;

  logic          accept;
  logic          empty;
  logic [AW-1:0] slot;
  logic [CW:0]   slot_p1;
  logic          shift_first;
  logic [CW:0]   shift_nx;
  logic          shift_more;
  logic [CW-1:0] rm_count;
  logic [CW-1:0] rm_cursor;

  assign accept      = cmd_valid_i && (state_q == S_IDLE);
  assign empty       = (count_q == '0);
  assign slot        = (cursor_q != '0) ? AW'(cursor_q - 1'b1) : '0;
  assign slot_p1     = (CW + 1)'(slot) + 1'b1;
  assign shift_first = slot_p1 < (CW + 1)'(count_q);
  assign shift_nx    = (CW + 1)'(idx_q) + 2'd2;
  assign shift_more  = shift_nx < (CW + 1)'(count_q);
  assign rm_count    = count_q - 1'b1;
  assign rm_cursor   = (cursor_q > rm_count) ? rm_count : cursor_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (!empty && op_i == OP_GET) begin
            state_d = S_RD_WAIT;
          end else if (!empty && op_i == OP_REMOVE && shift_first) begin
            state_d = S_SHIFT;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_RD_WAIT: state_d = S_DONE;
      S_SHIFT: begin
        if (!shift_more) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    count_d  = count_q;
    cursor_d = cursor_q;
    idx_d    = idx_q;
    status_d = status_q;
    rdval_d  = rdval_q;
    we_o     = 1'b0;
    waddr_o  = '0;
    wdata_o  = data_i;
    re_o     = 1'b0;
    raddr_o  = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          status_d = ST_OK;
          rdval_d  = '0;
          unique case (op_i)
            OP_START: begin
              if (empty) status_d = ST_EMPTY;
              else cursor_d = CW'(1);
            end
            OP_END: begin
              if (empty) status_d = ST_EMPTY;
              else cursor_d = count_q;
            end
            OP_NEXT: begin
              if (empty) status_d = ST_EMPTY;
              else if (cursor_q >= count_q) status_d = ST_RANGE;
              else cursor_d = cursor_q + 1'b1;
            end
            OP_BACK: begin
              if (empty) status_d = ST_EMPTY;
              else if (cursor_q <= CW'(1)) status_d = ST_RANGE;
              else cursor_d = cursor_q - 1'b1;
            end
            OP_GET: begin
              if (empty) begin
                status_d = ST_EMPTY;
              end else begin
                re_o    = 1'b1;
                raddr_o = slot;
              end
            end
            OP_UPDATE: begin
              if (empty) begin
                status_d = ST_EMPTY;
              end else begin
                we_o    = 1'b1;
                waddr_o = slot;
              end
            end
            OP_APPEND: begin
              if (count_q >= CW'(CAPACITY)) begin
                status_d = ST_FULL;
              end else begin
                we_o    = 1'b1;
                waddr_o = AW'(count_q);
                count_d = count_q + 1'b1;
                if (empty) cursor_d = CW'(1);
              end
            end
            OP_REMOVE: begin
              if (empty) begin
                status_d = ST_EMPTY;
              end else if (shift_first) begin
                re_o    = 1'b1;
                raddr_o = AW'(slot_p1);
                idx_d   = slot;
              end else begin
                count_d  = rm_count;
                cursor_d = rm_cursor;
              end
            end
            OP_CLEAR: begin
              count_d  = '0;
              cursor_d = '0;
            end
            default: ;
          endcase
        end
      end
      S_RD_WAIT: rdval_d = rdata_i;
      S_SHIFT: begin
        // move the element read last cycle down one place
        we_o    = 1'b1;
        waddr_o = idx_q;
        wdata_o = rdata_i;
        if (shift_more) begin
          re_o    = 1'b1;
          raddr_o = AW'(shift_nx);
          idx_d   = idx_q + 1'b1;
        end else begin
          count_d  = rm_count;
          cursor_d = rm_cursor;
        end
      end
      S_DONE: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      cursor_q <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      cursor_q <= cursor_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    status_q <= status_d;
    rdval_q  <= rdval_d;
  end

  assign cmd_ready_o  = (state_q == S_IDLE);
  assign res_o.valid  = (state_q == S_DONE);
  assign res_o.status = status_q;
  assign rd_val_o     = rdval_q;
  assign count_o      = count_q;
  assign cursor_o     = cursor_q;

endmodule

// ===== rtl/core/cursor_array_list_engine.sv =====
// response path: start, end, next, back, update, append, clear and a remove with no element
//   behind the cursor go straight to the done state; get passes the read wait state first
// remove: shifts the k elements behind the cursor (at most CAPACITY-1) down, one per cycle
// throughput: next command accepted once the previous response enters the output register
// reset: asynchronous, clears count, cursor, sequencer and response valid; list memory is
//   not cleared, entries past the count are never read
module cursor_array_list_engine
  import cale_pkg::*;
#(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cale_cmd_if.sink  cmd_i,
  cale_rsp_if.source rsp_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // sequencer to memory port
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;

  // sequencer to output stage
  res_t                         res;
  logic [DATA_WIDTH-1:0]        rd_val;
  logic signed [DATA_WIDTH-1:0] rd_val_s;
  logic [CW-1:0]                count;
  logic [CW-1:0]                cursor;
  logic                         res_take;
  logic                         load;

  // incoming value, sign extended or cut to the stored width
  logic signed [DATA_WIDTH-1:0] data_st;

  // output register
  logic                    rsp_valid_q, rsp_valid_d;
  logic signed [VAL_W-1:0] read_value_q;
  logic [STAT_W-1:0]       status_q;
  logic [CNT_OUT_W-1:0]    count_q;
  logic [CNT_OUT_W-1:0]    cursor_q;

  assign data_st  = DATA_WIDTH'(cmd_i.data_value);
  assign rd_val_s = rd_val;

  cale_ctrl #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_cale_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_i.valid),
    .cmd_ready_o (cmd_i.ready),
    .op_i        (op_e'(cmd_i.operation)),
    .data_i      (data_st),
    .res_take_i  (res_take),
    .res_o       (res),
    .rd_val_o    (rd_val),
    .count_o     (count),
    .cursor_o    (cursor),
    .we_o        (mem_we),
    .waddr_o     (mem_waddr),
    .wdata_o     (mem_wdata),
    .re_o        (mem_re),
    .raddr_o     (mem_raddr),
    .rdata_i     (mem_rdata)
  );

  cale_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_WIDTH)
  ) u_cale_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // output slot is free when empty or being drained this cycle
  assign res_take = !rsp_valid_q || rsp_o.ready;
  assign load     = res.valid && res_take;

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (load) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // payload: count and cursor are reported in 4 bits
  always_ff @(posedge clk_i) begin
    if (load) begin
      read_value_q <= VAL_W'(rd_val_s);
      status_q     <= res.status;
      count_q      <= CNT_OUT_W'(count);
      cursor_q     <= CNT_OUT_W'(cursor);
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.read_value    = read_value_q;
  assign rsp_o.status        = status_q;
  assign rsp_o.element_count = count_q;
  assign rsp_o.cursor_index  = cursor_q;

endmodule

// ===== rtl/core/cale_checker.sv =====
module cale_checker
  import cale_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    cmd_valid_i,
  input logic                    cmd_ready_i,
  input logic                    rsp_valid_i,
  input logic                    rsp_ready_i,
  input logic signed [VAL_W-1:0] read_value_i,
  input logic [STAT_W-1:0]       status_i,
  input logic [CNT_OUT_W-1:0]    element_count_i,
  input logic [CNT_OUT_W-1:0]    cursor_index_i
);

  // counts are only checkable while they fit the 4-bit fields
  localparam logic NARROW = (CAPACITY < 16);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(read_value_i)
      && $stable(status_i) && $stable(element_count_i) && $stable(cursor_index_i))
    else $error("response dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && cmd_ready_i |=> !cmd_ready_i)
    else $error("command taken while previous one still in work");

  a_cursor_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !NARROW || (element_count_i <= CNT_OUT_W'(CAPACITY)
      && cursor_index_i <= element_count_i))
    else $error("cursor or count out of range");

  a_cursor_iff_elements: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !NARROW || ((element_count_i == '0) == (cursor_index_i == '0)))
    else $error("cursor present without elements or missing with elements");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i == ST_FULL |-> !NARROW
      || element_count_i == CNT_OUT_W'(CAPACITY))
    else $error("full status while list not at capacity");

endmodule

bind cursor_array_list_engine cale_checker #(
  .CAPACITY (CAPACITY)
) u_cale_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .cmd_valid_i     (cmd_i.valid),
  .cmd_ready_i     (cmd_i.ready),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .read_value_i    (rsp_o.read_value),
  .status_i        (rsp_o.status),
  .element_count_i (rsp_o.element_count),
  .cursor_index_i  (rsp_o.cursor_index)
);

// ===== sim/cale_list_checker.sv =====
module cale_list_checker
  import cale_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cmd_valid_i,
  input  logic                    cmd_ready_i,
  input  logic [OP_W-1:0]         operation_i,
  input  logic signed [VAL_W-1:0] data_value_i,
  input  logic                    rsp_valid_i,
  input  logic                    rsp_ready_i,
  input  logic signed [VAL_W-1:0] read_value_i,
  input  logic [STAT_W-1:0]       status_i,
  input  logic [CNT_OUT_W-1:0]    element_count_i,
  input  logic [CNT_OUT_W-1:0]    cursor_index_i,
  output int                      pending_o,
  output int                      fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAPACITY = CAPACITY_DEF;

  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    status_e                 status;
    logic [CNT_OUT_W-1:0]    element_count;
    logic [CNT_OUT_W-1:0]    cursor_index;
  } list_resp_t;

  // shadow copy of the list
  logic signed [VAL_W-1:0] list_mem [CAPACITY];
  int unsigned             list_len;
  int unsigned             cursor_pos;
  list_resp_t              resp_q [$];
  int                      fails;

  function automatic int unsigned cursor_slot();
    int unsigned s;
    s = (cursor_pos >= 1) ? cursor_pos - 1 : 0;
    return (s < CAPACITY) ? s : CAPACITY - 1;
  endfunction

  task automatic apply_command(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] val,
                               output list_resp_t resp);
    logic signed [VAL_W-1:0] rd;
    status_e                 st;
    int unsigned             slot;
    bit                      empty;
    rd    = '0;
    st    = ST_OK;
    slot  = cursor_slot();
    empty = (list_len == 0);
    case (op)
      OP_START: begin
        if (empty) st = ST_EMPTY;
        else cursor_pos = 1;
      end
      OP_END: begin
        if (empty) st = ST_EMPTY;
        else cursor_pos = list_len;
      end
      OP_NEXT: begin
        if (empty) st = ST_EMPTY;
        else if (cursor_pos >= list_len) st = ST_RANGE;
        else cursor_pos++;
      end
      OP_BACK: begin
        if (empty) st = ST_EMPTY;
        else if (cursor_pos <= 1) st = ST_RANGE;
        else cursor_pos--;
      end
      OP_GET: begin
        if (empty) st = ST_EMPTY;
        else rd = list_mem[slot];
      end
      OP_UPDATE: begin
        if (empty) st = ST_EMPTY;
        else list_mem[slot] = val;
      end
      OP_APPEND: begin
        if (list_len >= CAPACITY) begin
          st = ST_FULL;
        end else begin
          list_mem[list_len] = val;
          list_len++;
          if (list_len == 1) cursor_pos = 1;
        end
      end
      OP_REMOVE: begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          for (int unsigned i = slot; i + 1 < list_len; i++) list_mem[i] = list_mem[i + 1];
          list_len--;
          if (cursor_pos > list_len) cursor_pos = list_len;
        end
      end
      OP_CLEAR: begin
        list_len   = 0;
        cursor_pos = 0;
      end
      default: ;
    endcase
    resp.read_value    = rd;
    resp.status        = st;
    resp.element_count = CNT_OUT_W'(list_len);
    resp.cursor_index  = CNT_OUT_W'(cursor_pos);
  endtask

  task automatic report_failure(input string what, input list_resp_t want, input list_resp_t got);
    fails++;
    if (fails <= 10) begin
      $display("[%0t] %s: expected rd=%0d st=%0d cnt=%0d cur=%0d, got rd=%0d st=%0d cnt=%0d cur=%0d",
               $time, what, want.read_value, want.status, want.element_count, want.cursor_index,
               got.read_value, got.status, got.element_count, got.cursor_index);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    list_resp_t got;
    list_resp_t want;
    if (!rst_ni) begin
      resp_q.delete();
      list_len   = 0;
      cursor_pos = 0;
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        got.read_value    = read_value_i;
        got.status        = status_e'(status_i);
        got.element_count = element_count_i;
        got.cursor_index  = cursor_index_i;
        if (resp_q.size() == 0) begin
          report_failure("response with nothing outstanding", '0, got);
        end else begin
          want = resp_q.pop_front();
          if (got.read_value !== want.read_value || got.status !== want.status ||
              got.element_count !== want.element_count ||
              got.cursor_index !== want.cursor_index) begin
            report_failure("response mismatch", want, got);
          end
        end
      end
      if (cmd_valid_i && cmd_ready_i) begin
        apply_command(operation_i, data_value_i, want);
        resp_q.push_back(want);
      end
    end
    pending_o    = resp_q.size();
    fail_count_o = fails;
  end

endmodule

// ===== sim/tb_cursor_array_list_engine.sv =====
module tb_cursor_array_list_engine;
  import cale_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1450;
  // worst case is far below this, counting the slowest command (remove), sender gaps and stalls
  localparam int CYCLE_LIMIT  = 400000;
  // remove with a full list behind the cursor is the slowest command
  localparam int DRAIN_CYCLES = 20;

  // operation codes with no meaning, the block must answer them as a no-op
  localparam logic [OP_W-1:0] OP_SPARE_LO = 4'd9;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 4'd15;

  logic clk;
  logic rst_n;
  int   cycles;
  int   pending;
  int   fail_count;
  int   burst_left;

  cale_cmd_if cmd_if ();
  cale_rsp_if rsp_if ();

  cursor_array_list_engine dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cmd_i  (cmd_if),
    .rsp_o  (rsp_if)
  );

  // predicts every response and compares it, reports how many went wrong
  cale_list_checker u_list_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cmd_valid_i     (cmd_if.valid),
    .cmd_ready_i     (cmd_if.ready),
    .operation_i     (cmd_if.operation),
    .data_value_i    (cmd_if.data_value),
    .rsp_valid_i     (rsp_if.valid),
    .rsp_ready_i     (rsp_if.ready),
    .read_value_i    (rsp_if.read_value),
    .status_i        (rsp_if.status),
    .element_count_i (rsp_if.element_count),
    .cursor_index_i  (rsp_if.cursor_index),
    .pending_o       (pending),
    .fail_count_o    (fail_count)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run as a failure
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("cursor_array_list_engine test failed");
      $finish;
    end
  end

  // response side: ready follows a mode that changes every so often
  // modes: always ready, coin flip, mostly stalled, toggling every cycle
  initial begin : rsp_stall
    int mode;
    int left;
    mode          = 0;
    left          = 0;
    rsp_if.ready  = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(16, 160);
      end
      left--;
      case (mode)
        0:       rsp_if.ready = 1'b1;
        1:       rsp_if.ready = 1'($urandom_range(0, 1));
        2:       rsp_if.ready = ($urandom_range(0, 4) == 0);
        default: rsp_if.ready = ~rsp_if.ready;
      endcase
    end
  end

  // one command transfer, entered and left at a falling edge
  // valid stays high between items of a burst and is dropped for a random gap before a new burst
  task automatic send_cmd(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] val);
    int gap;
    if (burst_left == 0) begin
      cmd_if.valid = 1'b0;
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 4);
      repeat (gap) @(negedge clk);
      // now and then a long burst with no idling at all
      burst_left = ($urandom_range(0, 4) == 0) ? 80 : $urandom_range(1, 16);
    end
    burst_left--;
    cmd_if.valid      = 1'b1;
    cmd_if.operation  = op;
    cmd_if.data_value = val;
    do @(posedge clk); while (!cmd_if.ready);
    @(negedge clk);
  endtask

  // data with the sign extremes showing up often
  function automatic logic signed [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // command mix; a filling phase pushes the list to full, a draining one empties it
  function automatic logic [OP_W-1:0] pick_op(input bit filling);
    int r;
    int append_w;
    int remove_w;
    r        = $urandom_range(0, 99);
    append_w = filling ? 34 : 14;
    remove_w = filling ? 8 : 26;
    if (r < 2) return OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    if (r < 4) return OP_CLEAR;
    if (r < 4 + append_w) return OP_APPEND;
    if (r < 4 + append_w + remove_w) return OP_REMOVE;
    case ($urandom_range(0, 7))
      0:       return OP_START;
      1:       return OP_END;
      2, 3:    return OP_NEXT;
      4:       return OP_BACK;
      5, 6:    return OP_GET;
      default: return OP_UPDATE;
    endcase
  endfunction

  initial begin : stimulus
    bit filling;
    int phase_left;
    filling           = 1'b1;
    phase_left        = 0;
    burst_left        = 0;
    rst_n             = 1'b0;
    cmd_if.valid      = 1'b0;
    cmd_if.operation  = OP_START;
    cmd_if.data_value = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // clear on an empty list still answers ok
    send_cmd(OP_CLEAR, '0);
    // every cursor and data command on an empty list reports empty
    send_cmd(OP_START, '0);
    send_cmd(OP_END, '0);
    send_cmd(OP_NEXT, '0);
    send_cmd(OP_BACK, '0);
    send_cmd(OP_GET, '0);
    send_cmd(OP_UPDATE, 32'sh1234_5678);
    send_cmd(OP_REMOVE, '0);
    // fill to capacity with the data extremes, cursor lands on the first element
    send_cmd(OP_APPEND, 32'sh8000_0000);
    send_cmd(OP_APPEND, 32'sh7fff_ffff);
    send_cmd(OP_APPEND, '0);
    send_cmd(OP_APPEND, '1);
    send_cmd(OP_APPEND, 32'sh5555_5555);
    send_cmd(OP_APPEND, 32'shaaaa_aaaa);
    send_cmd(OP_APPEND, $urandom);
    send_cmd(OP_APPEND, $urandom);
    // append to a full list is refused
    send_cmd(OP_APPEND, $urandom);
    // back at the first element and next at the last one are out of range
    send_cmd(OP_BACK, '0);
    send_cmd(OP_GET, '0);
    send_cmd(OP_END, '0);
    send_cmd(OP_NEXT, '0);
    send_cmd(OP_UPDATE, rand_value());
    send_cmd(OP_GET, '0);
    // remove in the middle shifts the tail down
    send_cmd(OP_BACK, '0);
    send_cmd(OP_REMOVE, '0);
    // unused codes leave the state alone
    send_cmd(OP_SPARE_LO, $urandom);
    send_cmd(OP_SPARE_HI, $urandom);
    send_cmd(OP_CLEAR, '0);

    // random traffic in alternating fill and drain phases
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        filling    = ~filling;
        phase_left = $urandom_range(40, 120);
      end
      phase_left--;
      send_cmd(pick_op(filling), rand_value());
    end
    cmd_if.valid = 1'b0;

    // wait for every outstanding response, then let the block settle
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0) begin
      $display("cursor_array_list_engine test passed");
    end else begin
      $display("cursor_array_list_engine test failed");
    end
    $finish;
  end

endmodule
